>>> hdl/c_like_source_tokenizer_macros.svh
// Assertion macros used by the tokenizer queue.
`ifndef C_LIKE_SOURCE_TOKENIZER_MACROS_SVH
`define C_LIKE_SOURCE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTOK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctok assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctok assertion failed");

`endif

>>> hdl/ctok_pkg.sv
// Types and constants shared by the tokenizer modules.
`timescale 1ns / 1ps

package ctok_pkg;

    // Scan modes of the front end
    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_NUM     = 3'd1,
        M_IDENT   = 3'd2,
        M_OP      = 3'd3,
        M_SLASH   = 3'd4,
        M_COMMENT = 3'd5
    } mode_t;

    // Token kinds
    localparam logic [4:0] K_NUM     = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_OP      = 5'd2;
    localparam logic [4:0] K_LPAREN  = 5'd3;
    localparam logic [4:0] K_RPAREN  = 5'd4;
    localparam logic [4:0] K_LBRACE  = 5'd5;
    localparam logic [4:0] K_RBRACE  = 5'd6;
    localparam logic [4:0] K_SEMI    = 5'd7;
    localparam logic [4:0] K_COMMA   = 5'd8;
    localparam logic [4:0] K_KW_BASE = 5'd9;
    localparam logic [4:0] K_END     = 5'd17;

    // Operator codes
    localparam logic [3:0] OP_PLUS   = 4'd0;
    localparam logic [3:0] OP_MINUS  = 4'd1;
    localparam logic [3:0] OP_STAR   = 4'd2;
    localparam logic [3:0] OP_SLASH  = 4'd3;
    localparam logic [3:0] OP_ASSIGN = 4'd4;
    localparam logic [3:0] OP_LT     = 4'd5;
    localparam logic [3:0] OP_GT     = 4'd6;
    localparam logic [3:0] OP_NOT    = 4'd7;
    localparam logic [3:0] OP_EQEQ   = 4'd8;
    localparam logic [3:0] OP_LE     = 4'd9;
    localparam logic [3:0] OP_GE     = 4'd10;
    localparam logic [3:0] OP_NE     = 4'd11;

    // Keywords packed first byte lowest, with their lengths
    localparam int NUM_KW = 8;
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'h00000074_6E69,   // int
        48'h00000000_6669,   // if
        48'h00006573_6C65,   // else
        48'h00000072_6F66,   // for
        48'h00000066_6564,   // def
        48'h0074_6E69_7270,  // print
        48'h0074_7570_6E69,  // input
        48'h6E72_7574_6572   // return
    };
    localparam logic [7:0] KW_LEN [NUM_KW] = '{
        8'd3, 8'd2, 8'd4, 8'd3, 8'd3, 8'd5, 8'd5, 8'd6
    };

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // Queue depth in step records
    localparam int QDEPTH = 4;

    // One token as delivered on the output port
    typedef struct packed {
        logic [4:0]  kind;
        logic [3:0]  op;
        logic [15:0] start;
        logic [7:0]  len;
        logic [30:0] value;
        logic        ovf;
    } token_t;

    // All tokens caused by one input byte (count is 1 to 3)
    typedef struct packed {
        token_t [2:0] tok;
        logic [1:0]   count;
    } rec_t;

    // Front end to queue
    typedef struct packed {
        logic push;
        rec_t rec;
    } q_push_t;

    // Queue to back end
    typedef struct packed {
        logic valid;
        rec_t rec;
    } q_head_t;

endpackage

>>> hdl/ctok_front.sv
// Front end: accepts source bytes, keeps the scan state and builds step records.
`timescale 1ns / 1ps

module ctok_front #(
    parameter int POSITION_BITS   = 16,
    parameter int MAX_TOKEN_CHARS = 255
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       ch,
    input  logic             final_req,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             q_full,
    output ctok_pkg::q_push_t push
);
    import ctok_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_CHARS);

    // Scan state
    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [7:0]               len_reg, len_next;
    logic [30:0]              acc_reg, acc_next;
    logic [47:0]              win_reg, win_next;
    logic [7:0]               pend_reg, pend_next;
    logic                     ovf_reg, ovf_next;

    logic   accept;
    logic   is_dig, is_alp;
    logic   done, old_flush, cmp_emit, idle_emit;
    token_t idle_tok;
    logic [34:0] num_prod;

    function automatic logic [15:0] to_pos16(input logic [POSITION_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[15:0];
    endfunction

    function automatic logic [3:0] op_index(input logic [7:0] c);
        case (c)
            "+":     return OP_PLUS;
            "-":     return OP_MINUS;
            "*":     return OP_STAR;
            "/":     return OP_SLASH;
            "=":     return OP_ASSIGN;
            "<":     return OP_LT;
            ">":     return OP_GT;
            "!":     return OP_NOT;
            default: return OP_PLUS;
        endcase
    endfunction

    function automatic logic [3:0] cmp_index(input logic [7:0] c);
        case (c)
            "=":     return OP_EQEQ;
            "<":     return OP_LE;
            ">":     return OP_GE;
            "!":     return OP_NE;
            default: return OP_ASSIGN;
        endcase
    endfunction

    function automatic logic [4:0] ident_kind(input logic [7:0] len, input logic [47:0] win);
        logic [4:0] k;
        k = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (len == KW_LEN[i] && win == KW_TEXT[i]) begin
                k = K_KW_BASE + 5'(i);
            end
        end
        return k;
    endfunction

    function automatic logic is_pending(input mode_t m);
        return (m == M_NUM) || (m == M_IDENT) || (m == M_OP) || (m == M_SLASH);
    endfunction

    // Token for whatever is pending in the given state
    function automatic token_t flush_tok(
        input mode_t                    m,
        input logic [POSITION_BITS-1:0] st,
        input logic [7:0]               len,
        input logic [30:0]              acc,
        input logic [47:0]              win,
        input logic [7:0]               pend,
        input logic                     ovf
    );
        token_t t;
        t       = '0;
        t.start = to_pos16(st);
        unique case (m)
            M_NUM:
            begin
                t.kind  = K_NUM;
                t.len   = len;
                t.value = acc;
                t.ovf   = ovf;
            end
            M_IDENT:
            begin
                t.kind = ident_kind(len, win);
                t.len  = len;
                t.ovf  = ovf;
            end
            M_OP:
            begin
                t.kind = K_OP;
                t.op   = op_index(pend);
                t.len  = 8'd1;
            end
            M_SLASH:
            begin
                t.kind = K_OP;
                t.op   = OP_SLASH;
                t.len  = 8'd1;
            end
            default:
            begin
                t.kind = K_NUM;
            end
        endcase
        return t;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign is_dig   = (ch >= "0") && (ch <= "9");
    assign is_alp   = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z")) || (ch == "_");
    assign num_prod = {4'b0, acc_reg} * 35'd10 + {31'b0, ch[3:0]};

    // Next state of the scanner for the byte on the input
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        win_next   = win_reg;
        pend_next  = pend_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg + 1'b1;
        done       = 1'b0;
        old_flush  = 1'b0;
        cmp_emit   = 1'b0;
        idle_emit  = 1'b0;
        idle_tok   = '0;

        unique case (mode_reg)
            M_NUM:
            begin
                if (is_dig) begin
                    if (num_prod > {4'b0, NUM_MAX}) begin
                        acc_next = NUM_MAX;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = num_prod[30:0];
                    end
                    if (len_reg < MAX_LEN) begin
                        len_next = len_reg + 8'd1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    done = 1'b1;
                end else begin
                    old_flush = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (is_alp || is_dig) begin
                    for (int k = 0; k < 6; k++) begin
                        if (len_reg == 8'(k)) begin
                            win_next[8*k +: 8] = ch;
                        end
                    end
                    if (len_reg < MAX_LEN) begin
                        len_next = len_reg + 8'd1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    done = 1'b1;
                end else begin
                    old_flush = 1'b1;
                end
            end
            M_OP:
            begin
                if (ch == "=") begin
                    cmp_emit  = 1'b1;
                    mode_next = M_IDLE;
                    done      = 1'b1;
                end else begin
                    old_flush = 1'b1;
                end
            end
            M_SLASH:
            begin
                if (ch == "/") begin
                    mode_next = M_COMMENT;
                    done      = 1'b1;
                end else begin
                    old_flush = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (ch == "\n") begin
                    mode_next = M_IDLE;
                end
                done = 1'b1;
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase

        if (old_flush) begin
            mode_next = M_IDLE;
        end

        // Byte not consumed by a pending token: treat as in idle
        if (!done) begin
            idle_tok.start = to_pos16(pos_reg);
            idle_tok.len   = 8'd1;
            if (is_dig || is_alp || ch == "/" || ch == "=" || ch == "!" || ch == "<"
                || ch == ">") begin
                start_next = pos_reg;
                len_next   = 8'd1;
                ovf_next   = 1'b0;
                acc_next   = '0;
                win_next   = '0;
                if (is_dig) begin
                    mode_next = M_NUM;
                    acc_next  = {27'b0, ch[3:0]};
                end else if (is_alp) begin
                    mode_next = M_IDENT;
                    win_next  = {40'b0, ch};
                end else if (ch == "/") begin
                    mode_next = M_SLASH;
                end else begin
                    mode_next = M_OP;
                    pend_next = ch;
                end
            end else begin
                case (ch)
                    "+", "-", "*":
                    begin
                        idle_emit     = 1'b1;
                        idle_tok.kind = K_OP;
                        idle_tok.op   = op_index(ch);
                    end
                    "(":
                    begin
                        idle_emit     = 1'b1;
                        idle_tok.kind = K_LPAREN;
                    end
                    ")":
                    begin
                        idle_emit     = 1'b1;
                        idle_tok.kind = K_RPAREN;
                    end
                    "{":
                    begin
                        idle_emit     = 1'b1;
                        idle_tok.kind = K_LBRACE;
                    end
                    "}":
                    begin
                        idle_emit     = 1'b1;
                        idle_tok.kind = K_RBRACE;
                    end
                    ";":
                    begin
                        idle_emit     = 1'b1;
                        idle_tok.kind = K_SEMI;
                    end
                    ",":
                    begin
                        idle_emit     = 1'b1;
                        idle_tok.kind = K_COMMA;
                    end
                    default:
                    begin
                        idle_emit = 1'b0;
                    end
                endcase
            end
        end
    end

    // Tokens of this step, packed into a record in emission order
    always_comb
    begin
        token_t     cand [3];
        logic [2:0] candv;
        logic [1:0] n;

        cand[0]  = flush_tok(mode_reg, start_reg, len_reg, acc_reg, win_reg, pend_reg, ovf_reg);
        candv[0] = old_flush && is_pending(mode_reg);
        if (cmp_emit) begin
            cand[0]       = '0;
            cand[0].kind  = K_OP;
            cand[0].op    = cmp_index(pend_reg);
            cand[0].start = to_pos16(start_reg);
            cand[0].len   = 8'd2;
            candv[0]      = 1'b1;
        end

        if (idle_emit) begin
            cand[1]  = idle_tok;
            candv[1] = 1'b1;
        end else begin
            cand[1]  = flush_tok(mode_next, start_next, len_next, acc_next, win_next,
                                 pend_next, ovf_next);
            candv[1] = final_req && is_pending(mode_next);
        end

        cand[2]       = '0;
        cand[2].kind  = K_END;
        cand[2].start = to_pos16(pos_next);
        candv[2]      = final_req;

        push.rec = '0;
        n        = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (candv[i]) begin
                push.rec.tok[n] = cand[i];
                n               = n + 2'd1;
            end
        end
        push.rec.count = n;
        push.push      = accept && (n != 2'd0);
    end

    // Scan state registers; the final byte returns everything to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            win_reg   <= '0;
            pend_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else if (accept) begin
            if (final_req) begin
                mode_reg  <= M_IDLE;
                pos_reg   <= '0;
                start_reg <= '0;
                len_reg   <= '0;
                acc_reg   <= '0;
                win_reg   <= '0;
                pend_reg  <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                acc_reg   <= acc_next;
                win_reg   <= win_next;
                pend_reg  <= pend_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

>>> hdl/ctok_queue.sv
// Step record queue between the front end and the back end.
`timescale 1ns / 1ps

`include "c_like_source_tokenizer_macros.svh"

module ctok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  ctok_pkg::q_push_t push,
    output logic              full,
    input  logic              pop,
    output ctok_pkg::q_head_t head
);
    import ctok_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    rec_t             mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push.push;
    assign do_pop  = pop && (count_reg != '0);
    assign full    = (count_reg == CNT_W'(QDEPTH));

    assign head.valid = (count_reg != '0);
    assign head.rec   = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.rec;
        end
    end

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `CTOK_ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, push.push, count_reg != CNT_W'(QDEPTH))
    `CTOK_ASSERT_IMPLIES(a_empty_ptrs_equal, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg)
    `CTOK_ASSERT_NEXT(a_count_up, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `CTOK_ASSERT_IMPLIES(a_rec_nonzero, clk, rst_n, push.push, push.rec.count != 2'd0)

endmodule

>>> hdl/ctok_back.sv
// Back end: sends the tokens of each queued step record one per transaction.
`timescale 1ns / 1ps

module ctok_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ctok_pkg::q_head_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output ctok_pkg::token_t  tok,
    output logic              last_of_run
);
    import ctok_pkg::*;

    logic [1:0] idx_reg, idx_next;

    assign out_valid   = head.valid;
    assign tok         = head.rec.tok[idx_reg];
    assign last_of_run = (idx_reg == head.rec.count - 2'd1);
    assign pop         = out_valid && out_ready && last_of_run;

    // Token index within the head record
    always_comb
    begin
        idx_next = idx_reg;
        if (out_valid && out_ready) begin
            idx_next = last_of_run ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> hdl/c_like_source_tokenizer.sv
// Top level of the streaming tokenizer for a small C-like language.
`timescale 1ns / 1ps

// Input channel: one source byte (ch, final_req) per transaction on in_valid/in_ready.
// Output channel: one token per transaction on out_valid/out_ready; last_of_run marks the
// last token caused by one input byte. A byte causes zero to three tokens.
// Throughput: one byte per cycle while the queue is not full; a byte with more tokens
// holds the output for one transaction per token. The front end scans every
// accepted byte in the cycle it arrives and writes its tokens as one record into a
// four-entry queue; the back end drains it one token per cycle while out_ready is high.
// A token is written to the queue with its byte and offered once it reaches the head.
// A token ending at a delimiter appears with that delimiter's byte.
// in_ready drops only when the queue is full, so a stalled receiver is absorbed by
// four records before the input stalls; nothing is lost or repeated.
// Reset clears the scan state, the position counter and the queue. After a byte with
// final_req the pending token and END are emitted and the next text starts at zero.
module c_like_source_tokenizer #(
    parameter int POSITION_BITS   = 16,
    parameter int MAX_TOKEN_CHARS = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  ch,
    input  logic        final_req,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [4:0]  token_kind,
    output logic [3:0]  op_code,
    output logic [15:0] start_pos,
    output logic [7:0]  token_len,
    output logic [30:0] number_value,
    output logic        overflowed,
    output logic        last_of_run,
    output logic        out_valid,
    input  logic        out_ready
);
    import ctok_pkg::*;

    q_push_t q_push;
    q_head_t q_head;
    logic    q_full;
    logic    q_pop;
    token_t  tok;

    ctok_front #(
        .POSITION_BITS   (POSITION_BITS),
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .final_req (final_req),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_full    (q_full),
        .push      (q_push)
    );

    ctok_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head)
    );

    ctok_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tok         (tok),
        .last_of_run (last_of_run)
    );

    // Token fields onto the output ports
    assign token_kind   = tok.kind;
    assign op_code      = tok.op;
    assign start_pos    = tok.start;
    assign token_len    = tok.len;
    assign number_value = tok.value;
    assign overflowed   = tok.ovf;

endmodule
